### src/ds_twr_ranging_round_robin_defines.svh
// assertion macros for the ranging slot engine
`ifndef DS_TWR_RANGING_ROUND_ROBIN_DEFINES_SVH
`define DS_TWR_RANGING_ROUND_ROBIN_DEFINES_SVH
`ifndef SYNTHESIS
`define DTR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DTR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define DTR_ASSERT(label, clk, rst_n, prop, msg)
`define DTR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### src/dtr_pkg.sv
package dtr_pkg;

  localparam int unsigned MaxAgents = 8;
  localparam int unsigned StampBits = 40;
  localparam int unsigned AgentBits = 3;
  localparam int unsigned ProdBits  = 64;
  localparam int unsigned TofBits   = 32;

  typedef logic [StampBits-1:0] stamp_t;

  localparam logic [1:0] FuncTx      = 2'd0;
  localparam logic [1:0] FuncRx      = 2'd1;
  localparam logic [1:0] FuncTimeout = 2'd2;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindResult  = 2'd1;
  localparam logic [1:0] KindStatus  = 2'd2;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StSeqErr  = 3'd1;
  localparam logic [2:0] StLost    = 3'd2;
  localparam logic [2:0] StZeroDen = 3'd3;
  localparam logic [2:0] StTimeout = 3'd4;

  localparam logic CfgAgents = 1'b0;
  localparam logic CfgOwn    = 1'b1;

  typedef struct packed {
    logic [1:0]           func;
    logic [AgentBits-1:0] sender;
    logic [7:0]           msg_iteration;
    stamp_t               stamp;
    stamp_t               peer_delta;
    stamp_t               peer_correction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [AgentBits-1:0] peer;
    logic [TofBits-1:0]   flight_time;
    stamp_t               round_delta;
    stamp_t               reply_correction;
    logic [2:0]           status;
    logic [MaxAgents-1:0] connected;
    logic                 last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAY,
    S_MUL,
    S_SUM,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

endpackage

### src/ds_twr_ranging_round_robin.sv
// channel  direction  handshake        payload
// in       input      in_valid/stall   dtr_pkg::in_item_t
// out      output     out_valid/stall  dtr_pkg::out_item_t
// cfg      input      cfg_valid/ready  index 1 bit, data 8 bits
// a transmit item in the own slot emits one payload entry per cycle unless the output stalls,
// agents_count entries (clamped 2..8), then a close state; a matching message runs 8 multiply
// steps (20x20 partial products), a sum step and a 64-step restoring divider, then loads
// its result in S_FIN and closes in S_OUT; a zero denominator skips the divider to S_FIN
// timeouts and sequence errors outside own slot load a status item; input stalled while busy
// reset clears all per-peer stores, speaker loads own index (0)
// results wait in an output register; an output stall holds the engine
`include "ds_twr_ranging_round_robin_defines.svh"
module ds_twr_ranging_round_robin (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dtr_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dtr_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  localparam int unsigned AB = dtr_pkg::AgentBits;
  localparam int unsigned PB = dtr_pkg::ProdBits;
  localparam int unsigned HB = dtr_pkg::StampBits / 2;
  localparam int unsigned MulSteps = 8;

  // next slot index, (s + 1) mod n by repeated subtraction
  function automatic logic [AB-1:0] wrap_next(logic [AB-1:0] s, logic [AB:0] n);
    logic [AB:0] r;
    r = {1'b0, s} + 1'b1;
    for (int k = 0; k < dtr_pkg::MaxAgents / 2; k++) begin
      if (r >= n) r = r - n;
    end
    return r[AB-1:0];
  endfunction

  dtr_pkg::state_e state_q, state_d;

  logic [3:0]    agents_q;
  logic [AB-1:0] own_q;
  logic [AB-1:0] spk_q;
  logic [7:0]    iter_q;
  logic [1:0]    err_q;
  logic [dtr_pkg::MaxAgents-1:0] conn_q;
  dtr_pkg::stamp_t last_tx_q;

  dtr_pkg::stamp_t rx_q [dtr_pkg::MaxAgents];
  dtr_pkg::stamp_t dl_q [dtr_pkg::MaxAgents];
  dtr_pkg::stamp_t cr_q [dtr_pkg::MaxAgents];
  logic [dtr_pkg::TofBits-1:0] tof_q [dtr_pkg::MaxAgents];

  dtr_pkg::in_item_t it_q;       // captured item
  logic [AB:0]       idx_q;      // payload walk
  logic [PB-1:0]     acc_q;      // numerator, then remainder
  logic [PB-1:0]     den_q;
  logic [PB-1:0]     quo_q;
  dtr_pkg::stamp_t   ca_q;
  logic [6:0]        cnt_q;      // multiply step, then divider step

  logic out_valid_q;
  dtr_pkg::out_item_t out_q;

  // effective agent count, clamped
  logic [AB:0] cnt_eff;
  always_comb begin
    if (agents_q < 4'd2) cnt_eff = (AB+1)'(2);
    else if (agents_q > 4'(dtr_pkg::MaxAgents)) cnt_eff = (AB+1)'(dtr_pkg::MaxAgents);
    else cnt_eff = agents_q[AB:0];
  end

  logic own_slot;
  logic [AB-1:0] spk_next;
  assign own_slot = (spk_q == own_q);
  assign spk_next = wrap_next(spk_q, cnt_eff);

  logic out_free;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != dtr_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == dtr_pkg::S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // message that never went through the arithmetic: sequence error
  logic seq_err;
  assign seq_err = (cnt_q == '0) &&
                   (it_q.msg_iteration != iter_q || it_q.sender != spk_q);

  // output register load
  logic out_load;
  always_comb begin
    out_load = 1'b0;
    if (out_free) begin
      case (state_q)
        dtr_pkg::S_PAY: out_load = 1'b1;
        dtr_pkg::S_FIN: out_load = 1'b1;
        dtr_pkg::S_OUT: out_load = (it_q.func != dtr_pkg::FuncTx) &&
                                   (it_q.func == dtr_pkg::FuncTimeout || seq_err);
        default: out_load = 1'b0;
      endcase
    end
  end

  // shared multiplier: one 20x20 partial product per step
  // steps 0-3 build da*peer_delta, steps 4-7 take off ca*peer_correction
  dtr_pkg::stamp_t op_a, op_b;
  logic [HB-1:0]   mul_a, mul_b;
  logic [2*HB-1:0] mul_p;
  logic [PB-1:0]   part;
  // divider step
  logic [PB:0]   rem_sh;
  logic [PB:0]   rem_sub;
  dtr_pkg::stamp_t ca_new;

  assign ca_new = last_tx_q - rx_q[it_q.sender];

  always_comb begin
    if (!cnt_q[2]) begin
      op_a = dl_q[it_q.sender];
      op_b = it_q.peer_delta;
    end else begin
      op_a = ca_q;
      op_b = it_q.peer_correction;
    end
    mul_a = cnt_q[1] ? op_a[2*HB-1:HB] : op_a[HB-1:0];
    mul_b = cnt_q[0] ? op_b[2*HB-1:HB] : op_b[HB-1:0];
  end
  assign mul_p = mul_a * mul_b;

  // partial product placed at its weight, wrapped to 64 bits
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    part = PB'(mul_p);
      2'd1:    part = PB'(mul_p) << HB;
      2'd2:    part = PB'(mul_p) << HB;
      default: part = PB'(mul_p) << (2*HB);
    endcase
  end

  assign rem_sh  = {acc_q, quo_q[PB-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dtr_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.func)
            dtr_pkg::FuncTx:      if (own_slot) state_d = dtr_pkg::S_PAY;
            dtr_pkg::FuncRx: begin
              if (!own_slot) begin
                if (in_data_i.msg_iteration != iter_q || in_data_i.sender != spk_q)
                  state_d = dtr_pkg::S_OUT;
                else
                  state_d = dtr_pkg::S_MUL;
              end
            end
            dtr_pkg::FuncTimeout: if (!own_slot) state_d = dtr_pkg::S_OUT;
            default: state_d = dtr_pkg::S_IDLE;
          endcase
        end
      end
      dtr_pkg::S_PAY: if (out_free && idx_q + 1'b1 >= cnt_eff) state_d = dtr_pkg::S_OUT;
      dtr_pkg::S_MUL:  if (cnt_q == 7'(MulSteps-1)) state_d = dtr_pkg::S_SUM;
      dtr_pkg::S_SUM:  state_d = (den_q == '0) ? dtr_pkg::S_FIN : dtr_pkg::S_DIV;
      dtr_pkg::S_DIV:  if (cnt_q == 7'(PB-1)) state_d = dtr_pkg::S_FIN;
      dtr_pkg::S_FIN:  if (out_free) state_d = dtr_pkg::S_OUT;
      dtr_pkg::S_OUT:  if (out_free) state_d = dtr_pkg::S_IDLE;
      default: state_d = dtr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dtr_pkg::S_IDLE;
    else state_q <= state_d;
  end

  // datapath and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agents_q    <= 4'd2;
      own_q       <= '0;
      spk_q       <= '0;
      iter_q      <= '0;
      err_q       <= '0;
      conn_q      <= '0;
      last_tx_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      it_q        <= '0;
      idx_q       <= '0;
      acc_q       <= '0;
      den_q       <= '0;
      quo_q       <= '0;
      ca_q        <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < dtr_pkg::MaxAgents; i++) begin
        rx_q[i]  <= '0;
        dl_q[i]  <= '0;
        cr_q[i]  <= '0;
        tof_q[i] <= '0;
      end
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == dtr_pkg::CfgAgents) agents_q <= cfg_data_i[3:0];
        else begin
          own_q <= cfg_data_i[AB-1:0];
          spk_q <= cfg_data_i[AB-1:0];
        end
      end
      case (state_q)
        dtr_pkg::S_IDLE: begin
          if (in_acc) begin
            it_q  <= in_data_i;
            idx_q <= '0;
          end
        end
        dtr_pkg::S_PAY: begin
          if (out_free) begin
            out_q.kind             <= dtr_pkg::KindPayload;
            out_q.peer             <= idx_q[AB-1:0];
            out_q.flight_time      <= tof_q[idx_q[AB-1:0]];
            out_q.round_delta      <= dl_q[idx_q[AB-1:0]];
            out_q.reply_correction <= cr_q[idx_q[AB-1:0]];
            out_q.status           <= dtr_pkg::StOk;
            out_q.connected        <= conn_q;
            out_q.last             <= (idx_q + 1'b1 >= cnt_eff);
            idx_q <= idx_q + 1'b1;
          end
        end
        dtr_pkg::S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '0) begin
            acc_q <= part;
            ca_q  <= ca_new;
            cr_q[it_q.sender] <= ca_new;
            rx_q[it_q.sender] <= it_q.stamp;
            den_q <= PB'(dl_q[it_q.sender]) + PB'(it_q.peer_delta);
          end else begin
            if (!cnt_q[2]) acc_q <= acc_q + part;
            else acc_q <= acc_q - part;
            // denominator picks up the correction terms one per step
            if (cnt_q == 7'd4) den_q <= den_q + PB'(ca_q);
            else if (cnt_q == 7'd5) den_q <= den_q + PB'(it_q.peer_correction);
          end
        end
        dtr_pkg::S_SUM: begin
          quo_q <= acc_q;
          acc_q <= '0;
          cnt_q <= '0;
        end
        dtr_pkg::S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (!rem_sub[PB]) begin
            acc_q <= rem_sub[PB-1:0];
            quo_q <= {quo_q[PB-2:0], 1'b1};
          end else begin
            acc_q <= rem_sh[PB-1:0];
            quo_q <= {quo_q[PB-2:0], 1'b0};
          end
        end
        dtr_pkg::S_FIN: begin
          if (out_free) begin
            tof_q[it_q.sender] <= (den_q == '0) ? '0 : quo_q[dtr_pkg::TofBits-1:0];
            dl_q[it_q.sender]  <= it_q.stamp - last_tx_q;
            conn_q[spk_q]      <= 1'b1;
            out_q.kind             <= dtr_pkg::KindResult;
            out_q.peer             <= it_q.sender;
            out_q.flight_time      <= (den_q == '0) ? '0 : quo_q[dtr_pkg::TofBits-1:0];
            out_q.round_delta      <= it_q.stamp - last_tx_q;
            out_q.reply_correction <= ca_q;
            out_q.status           <= (den_q == '0) ? dtr_pkg::StZeroDen : dtr_pkg::StOk;
            out_q.connected        <= conn_q | (dtr_pkg::MaxAgents'(1) << spk_q);
            out_q.last             <= 1'b1;
          end
        end
        dtr_pkg::S_OUT: begin
          if (out_free) begin
            // finish the event: status item or slot advance
            if (it_q.func == dtr_pkg::FuncTx) begin
              last_tx_q <= it_q.stamp;
              spk_q     <= spk_next;
              iter_q    <= iter_q + 1'b1;
            end else if (it_q.func == dtr_pkg::FuncTimeout) begin
              conn_q[spk_q] <= 1'b0;
              spk_q  <= spk_next;
              iter_q <= iter_q + 1'b1;
              out_q <= '{kind: dtr_pkg::KindStatus, peer: spk_q, flight_time: '0,
                         round_delta: '0, reply_correction: '0,
                         status: dtr_pkg::StTimeout,
                         connected: conn_q & ~(dtr_pkg::MaxAgents'(1) << spk_q),
                         last: 1'b1};
            end else if (seq_err) begin
              // sequence error path (never came through the divider)
              if (err_q == 2'd1) begin
                err_q <= '0;
                out_q <= '{kind: dtr_pkg::KindStatus, peer: spk_q, flight_time: '0,
                           round_delta: '0, reply_correction: '0,
                           status: dtr_pkg::StLost, connected: conn_q, last: 1'b1};
              end else begin
                err_q  <= err_q + 1'b1;
                spk_q  <= spk_next;
                iter_q <= iter_q + 1'b1;
                out_q <= '{kind: dtr_pkg::KindStatus, peer: spk_q, flight_time: '0,
                           round_delta: '0, reply_correction: '0,
                           status: dtr_pkg::StSeqErr, connected: conn_q, last: 1'b1};
              end
            end else begin
              spk_q  <= spk_next;
              iter_q <= iter_q + 1'b1;
            end
            cnt_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `DTR_ASSERT(a_busy_stall, clk_i, rst_ni,
    (state_q == dtr_pkg::S_IDLE) || in_stall_o, "input taken while busy")
  `DTR_ASSERT(a_cfg_idle, clk_i, rst_ni,
    !(cfg_ready_o && out_valid_o), "config ready with pending result")
  `DTR_ASSERT_NEXT(a_div_len, clk_i, rst_ni,
    state_q == dtr_pkg::S_DIV && cnt_q == 7'(PB-1), state_q == dtr_pkg::S_FIN,
    "divider overran")
  `DTR_ASSERT(a_err_range, clk_i, rst_ni, err_q != 2'd2 && err_q != 2'd3,
    "error count out of range")

endmodule

### verif/testbench.sv
module testbench;

  localparam int HalfPeriod = 6;
  localparam int CycleLimit = 600000;
  // longest quiet time of the engine after its last result (divider plus handoff)
  localparam int SettleCycles = 120;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  dtr_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dtr_pkg::out_item_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [7:0]         cfg_data_i = '0;

  ds_twr_ranging_round_robin uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // shadow copy of the engine: registers and per-peer stores
  logic [3:0]                    agents_reg;
  logic [2:0]                    own_reg;
  dtr_pkg::stamp_t               rx_stamp_mem [dtr_pkg::MaxAgents];
  dtr_pkg::stamp_t               delta_mem    [dtr_pkg::MaxAgents];
  dtr_pkg::stamp_t               corr_mem     [dtr_pkg::MaxAgents];
  logic [dtr_pkg::TofBits-1:0]   tof_mem      [dtr_pkg::MaxAgents];
  dtr_pkg::stamp_t               tx_stamp;
  logic [dtr_pkg::MaxAgents-1:0] link_mask;
  logic [7:0]                    slot_iter;
  int                            speaker;
  int                            miss_count;

  dtr_pkg::out_item_t pending_q[$];   // results the engine still owes
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b0;
  int        send_gap = 0;
  int        stall_burst = 0;

  function automatic int active_agents();
    if (agents_reg < 2) return 2;
    if (agents_reg > dtr_pkg::MaxAgents) return dtr_pkg::MaxAgents;
    return agents_reg;
  endfunction

  function automatic void next_slot();
    slot_iter = slot_iter + 8'd1;
    speaker = (speaker + 1) % active_agents();
  endfunction

  function automatic dtr_pkg::out_item_t make_result(logic [1:0] k, int p,
                                                     logic [dtr_pkg::TofBits-1:0] f,
                                                     dtr_pkg::stamp_t d, dtr_pkg::stamp_t c,
                                                     logic [2:0] s);
    dtr_pkg::out_item_t r;
    r.kind = k;
    r.peer = p[2:0];
    r.flight_time = f;
    r.round_delta = d;
    r.reply_correction = c;
    r.status = s;
    r.connected = '0;
    r.last = 1'b0;
    return r;
  endfunction

  // works out what the engine answers to one accepted item
  function automatic void predict_slot(dtr_pkg::in_item_t it);
    dtr_pkg::out_item_t res[$];
    logic [63:0] da, ca, num, den, quo;
    logic [2:0]  st;
    int          s;
    bit          own_slot;
    own_slot = (speaker == own_reg);
    case (it.func)
      dtr_pkg::FuncTx: begin
        if (own_slot) begin
          for (int i = 0; i < active_agents(); i++)
            res.push_back(make_result(dtr_pkg::KindPayload, i, tof_mem[i], delta_mem[i],
                                      corr_mem[i], dtr_pkg::StOk));
          tx_stamp = it.stamp;
          next_slot();
        end
      end
      dtr_pkg::FuncRx: begin
        if (!own_slot) begin
          if (it.msg_iteration != slot_iter || it.sender != speaker) begin
            // every second miss reports the link as lost and keeps the slot
            miss_count = (miss_count + 1) & 3;
            st = dtr_pkg::StSeqErr;
            s = speaker;
            if (miss_count >= 2) begin
              miss_count = 0;
              st = dtr_pkg::StLost;
            end else begin
              next_slot();
            end
            res.push_back(make_result(dtr_pkg::KindStatus, s, '0, '0, '0, st));
          end else begin
            s = it.sender;
            corr_mem[s] = tx_stamp - rx_stamp_mem[s];
            rx_stamp_mem[s] = it.stamp;
            da = {24'd0, delta_mem[s]};
            ca = {24'd0, corr_mem[s]};
            num = da * {24'd0, it.peer_delta} - ca * {24'd0, it.peer_correction};
            den = da + {24'd0, it.peer_delta} + ca + {24'd0, it.peer_correction};
            st = dtr_pkg::StOk;
            quo = '0;
            if (den == 0) st = dtr_pkg::StZeroDen;
            else quo = num / den;
            tof_mem[s] = quo[dtr_pkg::TofBits-1:0];
            delta_mem[s] = it.stamp - tx_stamp;
            link_mask[s] = 1'b1;
            res.push_back(make_result(dtr_pkg::KindResult, s, tof_mem[s], delta_mem[s],
                                      corr_mem[s], st));
            next_slot();
          end
        end
      end
      dtr_pkg::FuncTimeout: begin
        if (!own_slot) begin
          link_mask[speaker] = 1'b0;
          res.push_back(make_result(dtr_pkg::KindStatus, speaker, '0, '0, '0,
                                    dtr_pkg::StTimeout));
          next_slot();
        end
      end
      default: ;  // unknown event kind is dropped
    endcase
    foreach (res[k]) begin
      res[k].connected = link_mask;
      res[k].last = (k == res.size() - 1);
      pending_q.push_back(res[k]);
    end
  endfunction

  function automatic dtr_pkg::stamp_t rand_stamp();
    return {8'($urandom_range(0, 255)), $urandom()};
  endfunction

  // one item on the input channel; valid stays high between back-to-back items
  task automatic send_item(logic [1:0] f, int snd, logic [7:0] itr, dtr_pkg::stamp_t stp,
                           dtr_pkg::stamp_t pd, dtr_pkg::stamp_t pc);
    if (idle_on && send_gap == 0 && $urandom_range(0, 4) == 0)
      send_gap = $urandom_range(1, 10);
    if (send_gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (send_gap - 1) @(negedge clk_i);
      send_gap = 0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i.func = f;
    in_data_i.sender = snd[2:0];
    in_data_i.msg_iteration = itr;
    in_data_i.stamp = stp;
    in_data_i.peer_delta = pd;
    in_data_i.peer_correction = pc;
    do @(posedge clk_i); while (in_stall_o);
    predict_slot(in_data_i);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // wait for every owed result plus the engine's quiet time
  task automatic drain();
    release_input();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == dtr_pkg::CfgAgents) begin
      agents_reg = val[3:0];
    end else begin
      own_reg = val[2:0];
      speaker = own_reg;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // good message for the current slot, close in time to our last transmit unless wide
  task automatic send_good_message(bit wide);
    dtr_pkg::stamp_t stp;
    stp = wide ? rand_stamp() : tx_stamp + dtr_pkg::stamp_t'($urandom_range(1000, 400000));
    send_item(dtr_pkg::FuncRx, speaker, slot_iter, stp,
              wide ? rand_stamp() : dtr_pkg::stamp_t'($urandom_range(1000, 400000)),
              wide ? rand_stamp() : dtr_pkg::stamp_t'($urandom_range(0, 200000)));
  endtask

  // mostly well-formed slot traffic, some broken or ignored events mixed in
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (speaker == own_reg && pick < 85) begin
      send_item(dtr_pkg::FuncTx, $urandom_range(0, 7), 8'($urandom()),
                tx_stamp + dtr_pkg::stamp_t'($urandom()), rand_stamp(), rand_stamp());
    end else if (speaker != own_reg && pick < 70) begin
      send_good_message(pick < 8);
    end else if (pick < 80) begin
      send_item(dtr_pkg::FuncTimeout, $urandom_range(0, 7), 8'($urandom()), rand_stamp(),
                rand_stamp(), rand_stamp());
    end else if (pick < 90) begin
      // broken sequence: iteration or speaker off
      send_item(dtr_pkg::FuncRx, pick[0] ? speaker : $urandom_range(0, 7),
                pick[0] ? slot_iter + 8'($urandom_range(1, 255)) : slot_iter, rand_stamp(),
                rand_stamp(), rand_stamp());
    end else begin
      send_item(2'($urandom_range(0, 3)), $urandom_range(0, 7), 8'($urandom()), rand_stamp(),
                rand_stamp(), rand_stamp());
    end
  endtask

  // receiver stall bursts
  always @(negedge clk_i) begin
    if (!idle_on) begin
      out_stall_i = 1'b0;
      stall_burst = 0;
    end else if (stall_burst > 0) begin
      out_stall_i = 1'b1;
      stall_burst--;
    end else begin
      out_stall_i = 1'b0;
      if ($urandom_range(0, 6) == 0) stall_burst = $urandom_range(1, 10);
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // compare every accepted result against the oldest one owed
  always @(posedge clk_i) begin
    dtr_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        check_field("kind", want.kind, out_data_o.kind);
        check_field("peer", want.peer, out_data_o.peer);
        check_field("flight_time", want.flight_time, out_data_o.flight_time);
        check_field("round_delta", want.round_delta, out_data_o.round_delta);
        check_field("reply_correction", want.reply_correction, out_data_o.reply_correction);
        check_field("status", want.status, out_data_o.status);
        check_field("connected", want.connected, out_data_o.connected);
        check_field("last", want.last, out_data_o.last);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL ds_twr_ranging_round_robin");
      $finish;
    end
  end

  // every special case on a two-agent round, seen with no idling
  task automatic test_slot_cases();
    send_item(dtr_pkg::FuncTx, 0, 0, '0, '0, '0);                   // payload of zero stores
    send_item(dtr_pkg::FuncTx, 0, 0, '1, '1, '1);                   // transmit outside own slot
    send_item(2'd3, 7, 8'hff, '1, '1, '1);                          // unknown event kind
    send_item(dtr_pkg::FuncRx, 1, slot_iter, '0, '0, '0);           // zero denominator
    send_item(dtr_pkg::FuncRx, 1, slot_iter, '1, '1, '1);           // message in own slot
    send_item(dtr_pkg::FuncTimeout, 0, 0, '0, '0, '0);              // timeout in own slot
    send_item(dtr_pkg::FuncTx, 7, 8'hff, '1, '0, '0);               // transmit at top of range
    send_item(dtr_pkg::FuncRx, 1, slot_iter, 40'd5, '1, '1);        // stamp wraps, extreme peers
    send_item(dtr_pkg::FuncTx, 0, 0, 40'd100, '0, '0);
    send_item(dtr_pkg::FuncRx, 1, slot_iter + 8'd1, 40'd900, 40'd3, 40'd4);  // wrong iteration
    send_item(dtr_pkg::FuncTx, 0, 0, 40'd2000, '0, '0);
    send_item(dtr_pkg::FuncRx, 0, slot_iter, 40'd2500, 40'd3, 40'd4);  // wrong speaker, lost
    send_item(dtr_pkg::FuncTimeout, 5, 8'h5a, '1, '1, '1);          // receive timeout
    send_item(dtr_pkg::FuncTx, 0, 0, 40'd4000, '0, '0);
    send_good_message(1'b0);                                        // equal stamp pairs below
    send_item(dtr_pkg::FuncTx, 0, 0, tx_stamp, '0, '0);
    send_item(dtr_pkg::FuncRx, 1, slot_iter, tx_stamp, 40'd10, 40'd10);
    send_item(dtr_pkg::FuncTx, 0, 0, rand_stamp(), '0, '0);         // payload with live values
    drain();
  endtask

  // a sweep of round sizes and slot positions, extremes included
  task automatic test_round_settings();
    logic [3:0] counts [6] = '{4'd8, 4'd15, 4'd0, 4'd5, 4'd1, 4'd3};
    logic [2:0] owns   [6] = '{3'd7, 3'd3, 3'd1, 3'd4, 3'd0, 3'd6};
    for (int c = 0; c < 6; c++) begin
      write_reg(dtr_pkg::CfgAgents, {4'd0, counts[c]});
      write_reg(dtr_pkg::CfgOwn, {5'd0, owns[c]});
      idle_on = (c % 2 == 0);
      repeat (c == 5 ? 4 : 12) send_random_item();
      drain();
    end
  endtask

  // random slot traffic with idling, one pause for every owed result midway
  task automatic test_random_traffic();
    write_reg(dtr_pkg::CfgAgents, 8'd4);
    write_reg(dtr_pkg::CfgOwn, 8'd2);
    idle_on = 1'b1;
    for (int n = 0; n < 20; n++) begin
      if (n == 10) begin
        release_input();
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      send_random_item();
    end
  endtask

  // closing stretch, no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (12) send_random_item();
    drain();
  endtask

  initial begin
    agents_reg = 4'd2;
    own_reg = '0;
    foreach (rx_stamp_mem[i]) begin
      rx_stamp_mem[i] = '0;
      delta_mem[i] = '0;
      corr_mem[i] = '0;
      tof_mem[i] = '0;
    end
    tx_stamp = '0;
    link_mask = '0;
    slot_iter = '0;
    speaker = 0;
    miss_count = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_slot_cases();
    test_round_settings();
    test_random_traffic();
    test_full_rate();
    if (fail_count == 0) begin
      $display("PASS ds_twr_ranging_round_robin");
    end else begin
      $display("FAIL ds_twr_ranging_round_robin");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/dtr_pkg.sv
src/ds_twr_ranging_round_robin.sv
verif/testbench.sv
